// ===== hdl/mhi_pkg.sv =====
// shared types, constants and helpers of the monotone cubic hermite interpolator
// no dependencies

package mhi_pkg;

  localparam int SAMPLE_MAX_DEF = 32;
  localparam int SPI_W = 6;
  localparam logic [SPI_W-1:0] SPI_RESET = 6'd32;

  // widths of the shared arithmetic unit
  localparam int AW = 128;
  localparam int BW = 66;
  localparam int NW = 8;

  typedef logic [1:0] status_t;
  localparam status_t ST_SAMPLE = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_SHORT  = 2'd2;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef struct packed {
    logic          start;
    op_t           op;
    logic [NW-1:0] n;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // divide by 65536 with truncation toward zero
  function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
    logic signed [63:0] biased;
    biased = p + (p[63] ? 64'sd65535 : 64'sd0);
    return biased >>> 16;
  endfunction

endpackage

// ===== hdl/mhi_in_if.sv =====
// knot input channel: valid/ready handshake with request payload
// no dependencies

interface mhi_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] knot_x;
  logic signed [31:0] knot_y;

  modport source (output valid, req_type, knot_x, knot_y, input ready);
  modport sink   (input valid, req_type, knot_x, knot_y, output ready);
endinterface

// ===== hdl/mhi_out_if.sv =====
// sample output channel: valid/ready handshake with result payload
// no dependencies

interface mhi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic [1:0]         status;
  logic               last_of_run;

  modport source (output valid, sample_x, sample_y, status, last_of_run, input ready);
  modport sink   (input valid, sample_x, sample_y, status, last_of_run, output ready);
endinterface

// ===== hdl/monotone_cubic_hermite_interp.sv =====
// top level of the monotone cubic hermite interpolator: sequencer, knot state, output stage
// depends on mhi_pkg, mhi_in_if, mhi_out_if, mhi_alu
//
// usage
//   in_ch  : knots (req_type 0) or end of data (req_type 1), one transfer per item
//   out_ch : samples or status results; last_of_run marks the final result of an item
//   cfg    : cfg_we/cfg_wdata write samples_per_interval (clamped to 2..SAMPLE_MAX)
// timing
//   one item at a time; in_ch.ready is high only while the sequencer is idle
//   every multiply and divide runs on one shared shift-add / restoring unit,
//   one bit per cycle: divides walk 64 bits (128 for the harmonic slope),
//   multiplies walk as many bits as their small operand has
//   a new knot runs its secant divide; from the third knot on it then runs the
//   harmonic slope (unless trivial), interval setup and the per-sample terms
//   for each emitted sample
// reset
//   rst clears knot state and sets samples_per_interval to 32
// stalls
//   a finished result waits in the output register until out_ch.ready;
//   the sequencer holds and takes no new item meanwhile

module monotone_cubic_hermite_interp #(
  parameter int SAMPLE_MAX = mhi_pkg::SAMPLE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mhi_pkg::SPI_W-1:0]   cfg_wdata,
  mhi_in_if.sink                      in_ch,
  mhi_out_if.source                   out_ch
);
  import mhi_pkg::*;

  localparam int KW = (SAMPLE_MAX > 2) ? $clog2(SAMPLE_MAX) : 1;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_SEC  = 21'h000002,
    S_HSEL = 21'h000004,
    S_DEN1 = 21'h000008,
    S_DEN2 = 21'h000010,
    S_NUM1 = 21'h000020,
    S_NUM2 = 21'h000040,
    S_HDIV = 21'h000080,
    S_HC1  = 21'h000100,
    S_HC2  = 21'h000200,
    S_X1   = 21'h000400,
    S_X2   = 21'h000800,
    S_T1A  = 21'h001000,
    S_T1B  = 21'h002000,
    S_T2A  = 21'h004000,
    S_T2B  = 21'h008000,
    S_T3A  = 21'h010000,
    S_T3B  = 21'h020000,
    S_T3C  = 21'h040000,
    S_T3D  = 21'h080000,
    S_EMIT = 21'h100000
  } state_t;

  state_t state;
  logic   issued;

  // config and knot state
  logic [SPI_W-1:0]   spi;
  logic [1:0]         knots_seen;
  logic signed [31:0] x0, x1, y0, y1;
  logic signed [31:0] last_secant, pending_slope;

  // current item and working registers
  logic signed [31:0] kx, ky;
  logic               is_end;
  logic signed [31:0] s_reg, c_reg;
  logic [63:0]        den_reg;
  logic signed [63:0] hc1_reg, a2_reg, a3_reg, ysum;
  logic [KW-1:0]      k;

  // output register
  logic signed [31:0] out_x, out_y;
  status_t            out_st;
  logic               out_last;

  // shared unit hookup
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic signed [AW-1:0]  alu_a;
  logic signed [BW-1:0]  alu_b;
  logic signed [AW-1:0]  alu_res;
  logic signed [63:0]    r64;

  mhi_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp),
    .res (alu_res)
  );

  assign r64 = alu_res[63:0];

  // points per interval, clamped
  logic [6:0]        s_cl;
  logic [KW-1:0]     m;
  logic [2*KW-1:0]   mm;
  logic [2*KW-1:0]   w_mag;
  logic signed [2*KW:0] wv;

  always_comb begin
    if (spi < SPI_W'(2)) begin
      s_cl = 7'd2;
    end else if (32'(spi) > SAMPLE_MAX) begin
      s_cl = 7'(SAMPLE_MAX);
    end else begin
      s_cl = 7'(spi);
    end
    m     = KW'(s_cl - 7'd1);
    mm    = (2*KW)'(m) * (2*KW)'(m);
    w_mag = (2*KW)'(k) * (2*KW)'(m - k);
    wv    = -$signed({1'b0, w_mag});
  end

  // secant and harmonic slope terms
  logic signed [32:0] dy;
  logic [31:0]        h0, h1, hs0, hs1, m0, m1;
  logic [31:0]        t1, t2;
  logic [33:0]        t3;
  logic               trivial;
  logic signed [31:0] s_sat;

  always_comb begin
    dy = 33'(ky) - 33'(y1);
    h0 = 32'(x1 - x0);
    h1 = 32'(kx - x1);
    // bring both interval widths below 2^30
    if (h0[31] | h1[31]) begin
      hs0 = h0 >> 2;
      hs1 = h1 >> 2;
    end else if (h0[30] | h1[30]) begin
      hs0 = h0 >> 1;
      hs1 = h1 >> 1;
    end else begin
      hs0 = h0;
      hs1 = h1;
    end
    t1 = {hs1[30:0], 1'b0} + hs0;
    t2 = {hs0[30:0], 1'b0} + hs1;
    t3 = 34'(hs0 + hs1) * 34'd3;
    m0 = last_secant[31] ? 32'(-last_secant) : 32'(last_secant);
    m1 = s_reg[31] ? 32'(-s_reg) : 32'(s_reg);
    trivial = (last_secant == '0) || (s_reg == '0) || (last_secant[31] != s_reg[31]);
    s_sat = sat32(r64);
  end

  // interval terms
  logic signed [32:0] hi;
  logic signed [63:0] a1;

  always_comb begin
    hi = 33'(x1) - 33'(x0);
    a1 = 64'(y1) - 64'(y0);
  end

  // harmonic quotient saturation
  logic               q_ovf;
  logic [31:0]        q_lo;
  logic signed [31:0] c_harm;

  always_comb begin
    q_ovf = |alu_res[AW-1:32];
    q_lo  = alu_res[31:0];
    if (last_secant[31]) begin
      c_harm = (q_ovf || q_lo > 32'h80000000) ? 32'sh80000000 : $signed(-q_lo);
    end else begin
      c_harm = (q_ovf || q_lo[31]) ? 32'sh7fffffff : $signed(q_lo);
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a        = '0;
    alu_b        = '0;
    alu_req.op   = OP_MUL;
    alu_req.n    = NW'(1);
    unique case (state)
      S_SEC: begin
        alu_a      = AW'(dy) <<< 16;
        alu_b      = BW'(h1);
        alu_req.op = OP_DIV;
        alu_req.n  = NW'(64);
      end
      S_DEN1: begin
        alu_a     = AW'(t1);
        alu_b     = BW'(m1);
        alu_req.n = NW'(32);
      end
      S_DEN2: begin
        alu_a     = AW'(t2);
        alu_b     = BW'(m0);
        alu_req.n = NW'(32);
      end
      S_NUM1: begin
        alu_a     = AW'(t3);
        alu_b     = BW'(m1);
        alu_req.n = NW'(32);
      end
      S_NUM2: begin
        alu_a     = alu_res;
        alu_b     = BW'(m0);
        alu_req.n = NW'(32);
      end
      S_HDIV: begin
        alu_a      = alu_res;
        alu_b      = BW'(den_reg);
        alu_req.op = OP_DIV;
        alu_req.n  = NW'(AW);
      end
      S_HC1: begin
        alu_a     = AW'(hi);
        alu_b     = BW'(pending_slope);
        alu_req.n = NW'(32);
      end
      S_HC2: begin
        alu_a     = AW'(hi);
        alu_b     = BW'(c_reg);
        alu_req.n = NW'(32);
      end
      S_X1: begin
        alu_a     = AW'(hi);
        alu_b     = BW'(k);
        alu_req.n = NW'(KW);
      end
      S_T1A: begin
        alu_a     = AW'(a1);
        alu_b     = BW'(k);
        alu_req.n = NW'(KW);
      end
      S_T2A: begin
        alu_a     = AW'(a2_reg);
        alu_b     = BW'(wv);
        alu_req.n = NW'(2*KW);
      end
      S_T3A: begin
        alu_a     = AW'(a3_reg);
        alu_b     = BW'(k);
        alu_req.n = NW'(KW);
      end
      S_T3C: begin
        alu_a     = alu_res;
        alu_b     = BW'(wv);
        alu_req.n = NW'(2*KW);
      end
      S_X2, S_T1B, S_T3B: begin
        alu_a      = alu_res;
        alu_b      = BW'(m);
        alu_req.op = OP_DIV;
        alu_req.n  = NW'(64);
      end
      S_T2B, S_T3D: begin
        alu_a      = alu_res;
        alu_b      = BW'(mm);
        alu_req.op = OP_DIV;
        alu_req.n  = NW'(64);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  logic calc_state;
  assign calc_state = !(state == S_IDLE || state == S_HSEL || state == S_EMIT);
  assign alu_req.start = calc_state && !issued;

  logic in_xfer, out_xfer;
  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (state == S_EMIT);
  assign out_ch.sample_x    = out_x;
  assign out_ch.sample_y    = out_y;
  assign out_ch.status      = out_st;
  assign out_ch.last_of_run = out_last;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      spi <= SPI_RESET;
    end else if (cfg_we) begin
      spi <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      knots_seen    <= '0;
      x0            <= '0;
      x1            <= '0;
      y0            <= '0;
      y1            <= '0;
      last_secant   <= '0;
      pending_slope <= '0;
    end else begin
      if (alu_req.start) begin
        issued <= 1'b1;
      end
      if (alu_rsp.done) begin
        issued <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            kx <= in_ch.knot_x;
            ky <= in_ch.knot_y;
            if (in_ch.req_type) begin
              is_end <= 1'b1;
              if (knots_seen == 2'd2) begin
                // final interval closes with the last secant
                c_reg <= last_secant;
                state <= S_HC1;
              end else begin
                out_x         <= '0;
                out_y         <= '0;
                out_st        <= ST_SHORT;
                out_last      <= 1'b1;
                knots_seen    <= '0;
                x0            <= '0;
                x1            <= '0;
                y0            <= '0;
                y1            <= '0;
                last_secant   <= '0;
                pending_slope <= '0;
                state         <= S_EMIT;
              end
            end else if (knots_seen == 2'd0) begin
              x1         <= in_ch.knot_x;
              y1         <= in_ch.knot_y;
              knots_seen <= 2'd1;
            end else if (in_ch.knot_x <= x1) begin
              out_x    <= in_ch.knot_x;
              out_y    <= in_ch.knot_y;
              out_st   <= ST_REJECT;
              out_last <= 1'b1;
              state    <= S_EMIT;
            end else begin
              is_end <= 1'b0;
              state  <= S_SEC;
            end
          end
        end
        S_SEC: begin
          if (alu_rsp.done) begin
            s_reg <= s_sat;
            state <= S_HSEL;
          end
        end
        S_HSEL: begin
          if (knots_seen == 2'd1) begin
            pending_slope <= s_reg;
            last_secant   <= s_reg;
            knots_seen    <= 2'd2;
            x0            <= x1;
            y0            <= y1;
            x1            <= kx;
            y1            <= ky;
            state         <= S_IDLE;
          end else if (trivial) begin
            c_reg <= '0;
            state <= S_HC1;
          end else begin
            state <= S_DEN1;
          end
        end
        S_DEN1: begin
          if (alu_rsp.done) begin
            den_reg <= alu_res[63:0];
            state   <= S_DEN2;
          end
        end
        S_DEN2: begin
          if (alu_rsp.done) begin
            den_reg <= den_reg + alu_res[63:0];
            state   <= S_NUM1;
          end
        end
        S_NUM1: begin
          if (alu_rsp.done) begin
            state <= S_NUM2;
          end
        end
        S_NUM2: begin
          if (alu_rsp.done) begin
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (alu_rsp.done) begin
            c_reg <= c_harm;
            state <= S_HC1;
          end
        end
        S_HC1: begin
          if (alu_rsp.done) begin
            hc1_reg <= trunc16(r64);
            state   <= S_HC2;
          end
        end
        S_HC2: begin
          if (alu_rsp.done) begin
            // cubic coefficients of the local hermite form
            a2_reg <= a1 - hc1_reg;
            a3_reg <= hc1_reg + trunc16(r64) - (a1 <<< 1);
            k      <= '0;
            state  <= S_X1;
          end
        end
        S_X1: begin
          if (alu_rsp.done) begin
            state <= S_X2;
          end
        end
        S_X2: begin
          if (alu_rsp.done) begin
            out_x <= x0 + r64[31:0];
            state <= S_T1A;
          end
        end
        S_T1A: begin
          if (alu_rsp.done) begin
            state <= S_T1B;
          end
        end
        S_T1B: begin
          if (alu_rsp.done) begin
            ysum  <= 64'(y0) + r64;
            state <= S_T2A;
          end
        end
        S_T2A: begin
          if (alu_rsp.done) begin
            state <= S_T2B;
          end
        end
        S_T2B: begin
          if (alu_rsp.done) begin
            ysum  <= ysum + r64;
            state <= S_T3A;
          end
        end
        S_T3A: begin
          if (alu_rsp.done) begin
            state <= S_T3B;
          end
        end
        S_T3B: begin
          if (alu_rsp.done) begin
            state <= S_T3C;
          end
        end
        S_T3C: begin
          if (alu_rsp.done) begin
            state <= S_T3D;
          end
        end
        S_T3D: begin
          if (alu_rsp.done) begin
            out_y    <= sat32(ysum + r64);
            out_st   <= ST_SAMPLE;
            out_last <= (k == m);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            if (out_st != ST_SAMPLE) begin
              state <= S_IDLE;
            end else if (k != m) begin
              k     <= k + 1'b1;
              state <= S_X1;
            end else if (is_end) begin
              knots_seen    <= '0;
              x0            <= '0;
              x1            <= '0;
              y0            <= '0;
              y1            <= '0;
              last_secant   <= '0;
              pending_slope <= '0;
              state         <= S_IDLE;
            end else begin
              // interval done: advance the knot window
              pending_slope <= c_reg;
              last_secant   <= s_reg;
              x0            <= x1;
              y0            <= y1;
              x1            <= kx;
              y1            <= ky;
              state         <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_SAMPLE) |-> out_ch.last_of_run)
    else $error("status result not marked last");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_sample_index: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_SAMPLE) |-> (k <= m))
    else $error("sample index past interval end");

endmodule

// ===== hdl/mhi_alu.sv =====
// shared bit-serial unit: shift-add multiply and restoring divide, one bit per cycle
// depends on mhi_pkg

module mhi_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  mhi_pkg::alu_req_t            req,
  input  logic signed [mhi_pkg::AW-1:0] a,
  input  logic signed [mhi_pkg::BW-1:0] b,
  output mhi_pkg::alu_rsp_t            rsp,
  output logic signed [mhi_pkg::AW-1:0] res
);
  import mhi_pkg::*;

  logic          busy;
  logic          done;
  op_t           op_r;
  logic [NW-1:0] cnt;
  logic [AW-1:0] areg;
  logic [BW-2:0] breg;
  logic [AW-1:0] acc;
  logic [BW-1:0] rem;
  logic          neg;

  logic [AW-1:0] ma;
  logic [BW-1:0] mb;
  logic [BW-1:0] rem_sh;
  logic [BW-1:0] rem_sub;
  logic          ge;
  logic [AW-1:0] acc_add;

  always_comb begin
    ma      = a[AW-1] ? AW'(-a) : AW'(a);
    mb      = b[BW-1] ? BW'(-b) : BW'(b);
    rem_sh  = {rem[BW-2:0], areg[AW-1]};
    ge      = rem_sh >= {1'b0, breg};
    rem_sub = rem_sh - {1'b0, breg};
    acc_add = acc + areg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= req.n;
        neg  <= a[AW-1] ^ b[BW-1];
        acc  <= '0;
        rem  <= '0;
        breg <= mb[BW-2:0];
        // dividend top-aligned so only its n low bits are walked
        areg <= (req.op == OP_DIV) ? (ma << (NW'(AW) - req.n)) : ma;
      end else if (busy) begin
        case (op_r)
          OP_MUL: begin
            if (breg[0]) begin
              acc <= acc_add;
            end
            areg <= areg << 1;
            breg <= breg >> 1;
          end
          default: begin
            if (ge) begin
              rem <= rem_sub;
              acc <= {acc[AW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              acc <= {acc[AW-2:0], 1'b0};
            end
            areg <= areg << 1;
          end
        endcase
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res      = neg ? -$signed(acc) : $signed(acc);
  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of monotone_cubic_hermite_interp: knot streams, sample checks
// depends on mhi_pkg, mhi_in_if, mhi_out_if and the interpolator rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhi_pkg::*;

  localparam logic REQ_KNOT = 1'b0;
  localparam logic REQ_END  = 1'b1;
  localparam int   WATCHDOG_LIMIT = 30000;
  localparam int   HOLD_CYCLES    = 3000;
  localparam int   SETTLE_CYCLES  = 1500;

  typedef struct {
    logic               rt;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } knot_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    status_t            st;
    logic               last;
  } sample_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [SPI_W-1:0] cfg_wdata;

  mhi_in_if  in_ch ();
  mhi_out_if out_ch ();

  monotone_cubic_hermite_interp i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // stimulus waiting for the driver, and samples the interpolator still owes us
  knot_req_t pending_knots[$];
  sample_t   expected_samples[$];

  int  errors;
  int  knots_sent;
  int  samples_seen;
  int  rejects_seen;
  int  shorts_seen;
  bit  idle_en;
  bit  hold_done;

  // predictor state
  int      spi_setting;
  int      knots_held;
  longint  hist_x[2];
  longint  hist_y[2];
  longint  last_secant;
  longint  pending_slope;

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // weighted harmonic mean of two secants, zero when signs differ or one is zero
  function automatic longint harmonic_slope(input longint d0, input longint d1,
                                            input longint unsigned h0,
                                            input longint unsigned h1);
    bit neg;
    longint unsigned m0, m1, den, a;
    logic [127:0] prod, quo;
    if (d0 == 0 || d1 == 0 || ((d0 < 0) != (d1 < 0))) return 0;
    neg = d0 < 0;
    m0 = neg ? -d0 : d0;
    m1 = neg ? -d1 : d1;
    while (((h0 | h1) >> 30) != 0) begin
      h0 = h0 >> 1;
      h1 = h1 >> 1;
    end
    den = (2 * h1 + h0) * m1 + (2 * h0 + h1) * m0;
    a = 3 * (h0 + h1) * m1;
    prod = {64'd0, a} * {64'd0, m0};
    quo = prod / {64'd0, den};
    if (neg) begin
      if (quo > 128'd2147483648) return -64'sd2147483648;
      return -longint'(quo[63:0]);
    end
    if (quo > 128'd2147483647) return 64'sd2147483647;
    return longint'(quo[63:0]);
  endfunction

  // sample the held interval with its local hermite cubic
  task automatic sample_interval(input longint c1, input longint c2);
    sample_t r;
    longint s, m, h, x1, y1, hc1, hc2, a1, a2, a3, w, yv;
    s = spi_setting;
    if (s < 2) s = 2;
    if (s > SAMPLE_MAX_DEF) s = SAMPLE_MAX_DEF;
    m = s - 1;
    x1 = hist_x[0];
    y1 = hist_y[0];
    h = hist_x[1] - x1;
    hc1 = (h * c1) / 65536;
    hc2 = (h * c2) / 65536;
    a1 = hist_y[1] - y1;
    a2 = a1 - hc1;
    a3 = hc1 + hc2 - 2 * a1;
    for (longint k = 0; k <= m; k++) begin
      w = k * (k - m);
      yv = y1 + (a1 * k) / m + (a2 * w) / (m * m) + (((a3 * k) / m) * w) / (m * m);
      r.x = 32'(x1 + (k * h) / m);
      r.y = 32'(sat_q16(yv));
      r.st = ST_SAMPLE;
      r.last = (k == m);
      expected_samples.push_back(r);
    end
  endtask

  task automatic clear_knots();
    knots_held = 0;
    hist_x = '{0, 0};
    hist_y = '{0, 0};
    last_secant = 0;
    pending_slope = 0;
  endtask

  // advance the predictor by one accepted request
  task automatic predict_request(input knot_req_t q);
    sample_t r;
    longint x, y, h, sec, c;
    x = q.x;
    y = q.y;
    if (q.rt == REQ_END) begin
      if (knots_held >= 2) begin
        sample_interval(pending_slope, last_secant);
      end else begin
        r = '{x: 0, y: 0, st: ST_SHORT, last: 1'b1};
        expected_samples.push_back(r);
      end
      clear_knots();
      return;
    end
    if (knots_held == 0) begin
      hist_x[1] = x;
      hist_y[1] = y;
      knots_held = 1;
      return;
    end
    if (x <= hist_x[1]) begin
      r = '{x: q.x, y: q.y, st: ST_REJECT, last: 1'b1};
      expected_samples.push_back(r);
      return;
    end
    h = x - hist_x[1];
    sec = sat_q16(((y - hist_y[1]) * 65536) / h);
    if (knots_held == 1) begin
      pending_slope = sec;
      knots_held = 2;
    end else begin
      c = harmonic_slope(last_secant, sec, hist_x[1] - hist_x[0], h);
      sample_interval(pending_slope, c);
      pending_slope = c;
    end
    last_secant = sec;
    hist_x[0] = hist_x[1];
    hist_y[0] = hist_y[1];
    hist_x[1] = x;
    hist_y[1] = y;
  endtask

  // driver: presents queued requests, with a random gap after each one while idle_en is set
  int in_gap;
  always @(posedge clk) begin
    knot_req_t q;
    bit fire;
    fire = in_ch.valid && in_ch.ready;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (fire) begin
        q = '{rt: in_ch.req_type, x: in_ch.knot_x, y: in_ch.knot_y};
        predict_request(q);
        knots_sent++;
      end
      if (!in_ch.valid || fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_knots.size() != 0) begin
          q = pending_knots.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= q.rt;
          in_ch.knot_x <= q.x;
          in_ch.knot_y <= q.y;
          in_gap <= idle_en ? $urandom_range(0, 18) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, one long hold-off, compare each transfer
  int out_wait;
  int hold_left;
  int quiet_cycles;
  always @(posedge clk) begin
    sample_t e;
    bit fire;
    logic rdy;
    fire = out_ch.valid && out_ch.ready;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
      hold_left <= 0;
      quiet_cycles <= 0;
    end else begin
      if (fire) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time,
                   out_ch.sample_x, out_ch.sample_y, out_ch.status);
        end else begin
          e = expected_samples.pop_front();
          if (out_ch.sample_x !== e.x) begin
            errors++;
            $display("%0t: sample_x expected %0d got %0d", $time, e.x, out_ch.sample_x);
          end
          if (out_ch.sample_y !== e.y) begin
            errors++;
            $display("%0t: sample_y expected %0d got %0d", $time, e.y, out_ch.sample_y);
          end
          if (out_ch.status !== e.st) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, e.st, out_ch.status);
          end
          if (out_ch.last_of_run !== e.last) begin
            errors++;
            $display("%0t: last_of_run expected %0b got %0b", $time, e.last,
                     out_ch.last_of_run);
          end
          case (e.st)
            ST_REJECT: rejects_seen++;
            ST_SHORT:  shorts_seen++;
            default:   samples_seen++;
          endcase
        end
      end
      // watchdog on cycles without any transfer
      if (fire || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      rdy = out_ch.ready;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = (hold_left == 1);
      end else if (!hold_done && samples_seen == 150) begin
        // long hold-off while the driver keeps offering
        hold_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        rdy = 1'b0;
      end else if (fire || !out_ch.ready) begin
        if (fire) begin
          out_wait = idle_en ? $urandom_range(0, 18) : 0;
        end
        if (out_wait > 0) begin
          out_wait = out_wait - 1;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
      out_ch.ready <= rdy;
    end
  end

  task automatic add_req(input logic rt, input longint x, input longint y);
    knot_req_t q;
    q = '{rt: rt, x: 32'(x), y: 32'(y)};
    pending_knots.push_back(q);
  endtask

  task automatic write_spi(input logic [SPI_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    spi_setting = v;
  endtask

  // wait for everything to drain, then give the sequencer time to go idle
  task automatic drain();
    while (pending_knots.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one run of knots with random content, maybe some broken knots, then end
  task automatic add_run(input int max_knots, inout int items);
    int n, shape;
    longint x, y, step;
    n = $urandom_range(0, max_knots);
    shape = $urandom_range(0, 3);
    x = longint'($signed(32'($urandom))) - ((n > 0) ? 64'sd1 << 28 : 0);
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    y = longint'($signed(32'($urandom)));
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          // broken knot: x not increasing
          add_req(REQ_KNOT, x - $urandom_range(0, 1000), $urandom);
          items++;
        end
        step = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'h7fffffff)
                                           : $urandom_range(1, 1 << 20);
        if (x + step > 64'sd2147483647) break;
        x = x + step;
        case (shape)
          0: y = longint'($signed(32'($urandom)));
          1: y = y;
          default: y = y + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
        y = sat_q16(y);
      end
      add_req(REQ_KNOT, x, y);
      items++;
    end
    add_req(REQ_END, $urandom, $urandom);
    items++;
  endtask

  initial begin
    int items;
    logic [SPI_W-1:0] spi_list[6];
    spi_list = '{6'd2, 6'd0, 6'd5, 6'd63, 6'd9, 6'd3};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_KNOT;
    in_ch.knot_x = '0;
    in_ch.knot_y = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    idle_en = 1'b1;
    spi_setting = SPI_RESET;
    clear_knots();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset setting of 32 points: short ends, rejects, field extremes
    add_req(REQ_END, 0, 0);
    add_req(REQ_KNOT, 0, 0);
    add_req(REQ_END, -1, -1);
    add_req(REQ_KNOT, -64'sd2147483648, -64'sd2147483648);
    add_req(REQ_KNOT, -64'sd2147483648, 5);
    add_req(REQ_KNOT, 0, 64'sd2147483647);
    add_req(REQ_KNOT, 64'sd2147483647, -64'sd2147483648);
    add_req(REQ_END, 64'sd2147483647, 64'sd2147483647);
    drain();

    // two points per interval (below range): flat secant, saturating secants
    write_spi(6'd0);
    add_req(REQ_KNOT, 0, 100);
    add_req(REQ_KNOT, 65536, 100);
    add_req(REQ_KNOT, 131072, 300000);
    add_req(REQ_KNOT, 131073, 64'sd2147483647);
    add_req(REQ_KNOT, 131073, 7);
    add_req(REQ_KNOT, 131074, -64'sd2147483648);
    add_req(REQ_KNOT, 64'sd2147483647, 0);
    add_req(REQ_END, 0, 0);
    drain();

    // above range acts as the maximum: monotone rise, same-sign secants
    write_spi(6'd63);
    add_req(REQ_KNOT, -200000, -65536);
    add_req(REQ_KNOT, -100000, 0);
    add_req(REQ_KNOT, 300000, 900000);
    add_req(REQ_END, 0, 0);
    drain();

    // random runs across several settings, one phase without idling
    for (int p = 0; p < 6; p++) begin
      write_spi(spi_list[p]);
      idle_en = (p != 2);
      items = 0;
      while (items < ((spi_list[p] > 20) ? 10 : 28)) begin
        add_run((spi_list[p] > 20) ? 3 : 8, items);
      end
      drain();
    end

    $display("covered %0d requests: %0d samples, %0d rejected knots, %0d short ends",
             knots_sent, samples_seen, rejects_seen, shorts_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mhi_pkg.sv
hdl/mhi_in_if.sv
hdl/mhi_out_if.sv
hdl/mhi_alu.sv
hdl/monotone_cubic_hermite_interp.sv
tb/testbench.sv
